@@ rtl/ccp_pkg.sv @@
// Package for the CORDIC Cartesian-to-polar block: widths, constants, types and the arctangent table.
package ccp_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ITERATIONS  = 16;
    localparam int TABLE_LEN   = 24;
    localparam int NUM_ITER    = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
    localparam int GUARD_BITS  = 16;
    localparam int WW          = COORD_WIDTH + GUARD_BITS + 2;  // iteration coordinate width
    localparam int ZW          = 33;                            // Q.29 angle accumulator width
    localparam int ANGLE_W     = 16;
    localparam int TAB_IDX_W   = 5;
    localparam int GAIN_W      = 24;
    localparam int HI_W        = WW - GUARD_BITS;
    localparam int HIP_W       = HI_W + GAIN_W;
    localparam int LOP_W       = GUARD_BITS + GAIN_W;
    localparam int SUM_W       = HIP_W + 1;
    localparam int MAG_FULL_W  = SUM_W + 1 - 24;

    localparam logic signed [ZW-1:0] PI_Q29     = ZW'(64'sd1686629713);
    localparam logic signed [ZW-1:0] TWO_PI_Q29 = ZW'(64'sd3373259426);
    localparam logic [GAIN_W-1:0]    GAIN_Q24   = GAIN_W'(24'd10188014);

    // Coordinates and angle handed from cell to cell
    typedef struct packed {
        logic signed [WW-1:0] x;
        logic signed [WW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 origin;
    } ccp_vec_t;

    // Gain products and wrapped angle
    typedef struct packed {
        logic [HIP_W-1:0]     hi_prod;
        logic [LOP_W-1:0]     lo_prod;
        logic signed [ZW-1:0] z;
        logic                 origin;
    } ccp_prod_t;

    // atan(2^-i) in Q.29, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q29(input logic [TAB_IDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = ZW'(64'sd421657428);
            5'd1:    v = ZW'(64'sd248918915);
            5'd2:    v = ZW'(64'sd131521918);
            5'd3:    v = ZW'(64'sd66762579);
            5'd4:    v = ZW'(64'sd33510843);
            5'd5:    v = ZW'(64'sd16771758);
            5'd6:    v = ZW'(64'sd8387925);
            5'd7:    v = ZW'(64'sd4194219);
            5'd8:    v = ZW'(64'sd2097141);
            5'd9:    v = ZW'(64'sd1048575);
            5'd10:   v = ZW'(64'sd524288);
            5'd11:   v = ZW'(64'sd262144);
            5'd12:   v = ZW'(64'sd131072);
            5'd13:   v = ZW'(64'sd65536);
            5'd14:   v = ZW'(64'sd32768);
            5'd15:   v = ZW'(64'sd16384);
            5'd16:   v = ZW'(64'sd8192);
            5'd17:   v = ZW'(64'sd4096);
            5'd18:   v = ZW'(64'sd2048);
            5'd19:   v = ZW'(64'sd1024);
            5'd20:   v = ZW'(64'sd512);
            5'd21:   v = ZW'(64'sd256);
            5'd22:   v = ZW'(64'sd128);
            5'd23:   v = ZW'(64'sd64);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/ccp_prerot.sv @@
// Input stage: turn left-half-plane points by 180 degrees and add guard bits.
module ccp_prerot (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [ccp_pkg::COORD_WIDTH-1:0] x_coord,
    input  logic signed [ccp_pkg::COORD_WIDTH-1:0] y_coord,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output ccp_pkg::ccp_vec_t                     vec_out
);
    import ccp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    ccp_vec_t          vec_reg;
    ccp_vec_t          vec_next;
    logic signed [WW-1:0] x_ext;
    logic signed [WW-1:0] y_ext;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign vec_out   = vec_reg;

    // Negate a point with negative x and seed the angle with plus or minus pi
    always_comb begin
        x_ext      = WW'(x_coord);
        y_ext      = WW'(y_coord);
        vec_next.origin = (x_coord == '0) && (y_coord == '0);
        if (x_coord[COORD_WIDTH-1]) begin
            vec_next.x = (-x_ext) <<< GUARD_BITS;
            vec_next.y = (-y_ext) <<< GUARD_BITS;
            vec_next.z = y_coord[COORD_WIDTH-1] ? -PI_Q29 : PI_Q29;
        end else begin
            vec_next.x = x_ext <<< GUARD_BITS;
            vec_next.y = y_ext <<< GUARD_BITS;
            vec_next.z = '0;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on an accepted request
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            vec_reg <= vec_next;
        end
    end

endmodule

@@ rtl/ccp_cell.sv @@
// One CORDIC vectoring micro-rotation cell with its own pipeline register.
module ccp_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [ccp_pkg::TAB_IDX_W-1:0]    stage_idx,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  ccp_pkg::ccp_vec_t                vec_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ccp_pkg::ccp_vec_t                vec_out
);
    import ccp_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    ccp_vec_t             vec_reg;
    ccp_vec_t             vec_next;
    logic signed [WW-1:0] x_in;
    logic signed [WW-1:0] y_in;
    logic signed [WW-1:0] xs;
    logic signed [WW-1:0] ys;
    logic signed [ZW-1:0] step;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign vec_out   = vec_reg;

    // Rotate toward y = 0 by the sign of y
    always_comb begin
        x_in = vec_in.x;
        y_in = vec_in.y;
        xs   = x_in >>> stage_idx;
        ys   = y_in >>> stage_idx;
        step = atan_q29(stage_idx);
        vec_next.origin = vec_in.origin;
        if (y_in[WW-1]) begin
            vec_next.x = x_in - ys;
            vec_next.y = y_in + xs;
            vec_next.z = vec_in.z - step;
        end else begin
            vec_next.x = x_in + ys;
            vec_next.y = y_in - xs;
            vec_next.z = vec_in.z + step;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Advance payload on an accepted request
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            vec_reg <= vec_next;
        end
    end

endmodule

@@ rtl/ccp_post.sv @@
// Post stage: wrap the angle into -pi..pi and form the gain products of x.
module ccp_post (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ccp_pkg::ccp_vec_t    vec_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ccp_pkg::ccp_prod_t   prod_out
);
    import ccp_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    ccp_prod_t            prod_reg;
    ccp_prod_t            prod_next;
    logic signed [ZW-1:0] z_in;
    logic [HI_W-1:0]      x_hi;
    logic [GUARD_BITS-1:0] x_lo;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign prod_out  = prod_reg;

    // Wrap angle and multiply both halves of x by the gain
    always_comb begin
        z_in = vec_in.z;
        x_hi = vec_in.x[WW-1:GUARD_BITS];
        x_lo = vec_in.x[GUARD_BITS-1:0];
        if (z_in > PI_Q29) begin
            prod_next.z = z_in - TWO_PI_Q29;
        end else if (z_in < -PI_Q29) begin
            prod_next.z = z_in + TWO_PI_Q29;
        end else begin
            prod_next.z = z_in;
        end
        prod_next.hi_prod = HIP_W'(x_hi) * HIP_W'(GAIN_Q24);
        prod_next.lo_prod = LOP_W'(x_lo) * LOP_W'(GAIN_Q24);
        prod_next.origin  = vec_in.origin;
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            prod_reg <= prod_next;
        end
    end

endmodule

@@ rtl/ccp_out.sv @@
// Output register: round and saturate the magnitude, round the angle to Q3.13.
module ccp_out (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  ccp_pkg::ccp_prod_t                    prod_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ccp_pkg::COORD_WIDTH-1:0]       magnitude,
    output logic signed [ccp_pkg::ANGLE_W-1:0]    angle
);
    import ccp_pkg::*;

    localparam logic [MAG_FULL_W-1:0] MAG_MAX = MAG_FULL_W'({COORD_WIDTH{1'b1}});

    logic                     valid_reg;
    logic                     valid_next;
    logic [COORD_WIDTH-1:0]   mag_reg;
    logic [COORD_WIDTH-1:0]   mag_next;
    logic signed [ANGLE_W-1:0] ang_reg;
    logic signed [ANGLE_W-1:0] ang_next;
    logic [LOP_W:0]           lo_rnd;
    logic [SUM_W-1:0]         sum;
    logic [SUM_W:0]           sum_rnd;
    logic [MAG_FULL_W-1:0]    mag_full;
    logic signed [ZW-1:0]     z_in;
    logic [ZW-1:0]            z_abs;
    logic [ZW-1:0]            a_abs;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign magnitude = mag_reg;
    assign angle     = ang_reg;

    always_comb begin
        // Combine the gain products, round half up, saturate
        lo_rnd   = (LOP_W+1)'(prod_in.lo_prod) + (LOP_W+1)'(1 << (GUARD_BITS - 1));
        sum      = SUM_W'(prod_in.hi_prod) + SUM_W'(lo_rnd >> GUARD_BITS);
        sum_rnd  = (SUM_W+1)'(sum) + (SUM_W+1)'(1 << 23);
        mag_full = MAG_FULL_W'(sum_rnd >> 24);
        if (mag_full > MAG_MAX) begin
            mag_next = {COORD_WIDTH{1'b1}};
        end else begin
            mag_next = COORD_WIDTH'(mag_full);
        end
        // Round the angle to Q3.13 with halves away from zero
        z_in  = prod_in.z;
        z_abs = z_in[ZW-1] ? ZW'(-z_in) : ZW'(z_in);
        a_abs = (z_abs + ZW'(1 << 15)) >> 16;
        ang_next = z_in[ZW-1] ? -ANGLE_W'(a_abs) : ANGLE_W'(a_abs);
        // Origin reports zero length and zero angle
        if (prod_in.origin) begin
            mag_next = '0;
            ang_next = '0;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mag_reg <= mag_next;
            ang_reg <= ang_next;
        end
    end

endmodule

@@ rtl/cordic_cartesian_to_polar.sv @@
// Top level: CORDIC vectoring pipeline from Cartesian point to magnitude and angle.
//
//   Channel  Ports                               Direction  Contents
//   s_       s_valid s_ready s_x_coord s_y_coord  in         one point per request
//   m_       m_valid m_ready m_magnitude m_angle  out        length and Q3.13 angle
//
// One request per cycle sustained while m_ready stays high; the pipeline is the input stage,
// one cell per micro-rotation, the gain stage and the output register.
// Every stage has its own valid bit, so bubbles close up and a point is taken
// while a result waits on m_ready as long as any stage is free.
// Reset clears only the valid bits; no state survives between points.
module cordic_cartesian_to_polar (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ccp_pkg::COORD_WIDTH-1:0] s_x_coord,
    input  logic signed [ccp_pkg::COORD_WIDTH-1:0] s_y_coord,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ccp_pkg::COORD_WIDTH-1:0]       m_magnitude,
    output logic signed [ccp_pkg::ANGLE_W-1:0]    m_angle
);
    import ccp_pkg::*;

    ccp_vec_t  vec   [NUM_ITER+1];
    logic      vld   [NUM_ITER+1];
    logic      rdy   [NUM_ITER+1];
    ccp_prod_t prod;
    logic      prod_valid;
    logic      prod_ready;

    // Pre-rotate into the right half plane
    ccp_prerot u_prerot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .x_coord   (s_x_coord),
        .y_coord   (s_y_coord),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .vec_out   (vec[0])
    );

    // Chain of micro-rotation cells
    for (genvar i = 0; i < NUM_ITER; i++) begin : g_cell
        ccp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (TAB_IDX_W'(i)),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .vec_in    (vec[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .vec_out   (vec[i+1])
        );
    end

    // Wrap angle and form gain products
    ccp_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[NUM_ITER]),
        .in_ready  (rdy[NUM_ITER]),
        .vec_in    (vec[NUM_ITER]),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .prod_out  (prod)
    );

    // Round, saturate and present the result
    ccp_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .prod_in   (prod),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .magnitude (m_magnitude),
        .angle     (m_angle)
    );

endmodule
